// ===== design/assert_macros.svh =====
// Assertion macros used by lru_key_value_store.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPL(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst, a, c)
`define ASSERT_NEXT(label, clk, rst, a, c)
`endif
`endif

// ===== design/lkv_pkg.sv =====
`timescale 1ns / 1ps
package lkv_pkg;
  localparam int ENTRIES = 32;
  localparam int IDX_W = $clog2(ENTRIES);
  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam int KEY_BITS = 64;
  localparam int LEN_BITS = 20;
  localparam int BYTES_W = 26;

  typedef enum logic [1:0] {
    KIND_SET  = 2'd0,
    KIND_GET  = 2'd1,
    KIND_DEL  = 2'd2,
    KIND_RSVD = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    EV_STATUS  = 2'd0,
    EV_ADDED   = 2'd1,
    EV_UPDATED = 2'd2,
    EV_EVICTED = 2'd3
  } event_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_INVALID  = 2'd1,
    ST_NO_SPACE = 2'd2,
    ST_NOT_FND  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_ACT,
    S_TAIL,
    S_DROP,
    S_LIMIT,
    S_DONE
  } state_t;

  localparam logic [1:0] CFG_BYTE_LIMIT = 2'd0;
  localparam logic [1:0] CFG_ITEM_LIMIT = 2'd1;
  localparam logic [1:0] CFG_NODE_ID = 2'd2;
endpackage

// ===== design/lru_key_value_store.sv =====
`timescale 1ns / 1ps
// Channel  | Handshake          | Fields
// request  | start / busy       | kind, key, set_len, value_word, source_id, req_time
// config   | cfg_we             | cfg_index, cfg_data
// result   | out_valid (strobe) | event_kind, status, event_key .. last
// A set holds busy through a key scan over all entries on one shared comparator,
// the action, a limit check and the status; get, delete and rejected requests skip the check.
// Each limit eviction adds a tail walk, the drop and a new check.
// An insert into a full store adds a tail walk, the drop, a second scan and a second action.
// Reset (synchronous, rst high) empties the store and restores register defaults.
// Result beats come at most one per cycle on out_valid; the receiver cannot stall.
`include "assert_macros.svh"
module lru_key_value_store
  import lkv_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          kind,
  input  logic [KEY_BITS-1:0] key,
  input  logic [LEN_BITS-1:0] set_len,
  input  logic [31:0]         value_word,
  input  logic [7:0]          source_id,
  input  logic [31:0]         req_time,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [25:0]         cfg_data,
  output logic                out_valid,
  output logic [1:0]          event_kind,
  output logic [1:0]          status,
  output logic [KEY_BITS-1:0] event_key,
  output logic [LEN_BITS-1:0] event_len,
  output logic [31:0]         read_word,
  output logic [7:0]          event_source,
  output logic [31:0]         event_time,
  output logic [CNT_W-1:0]    entry_count,
  output logic [BYTES_W-1:0]  bytes_used,
  output logic                last
);

  // Configuration registers.
  logic [BYTES_W-1:0] byte_limit;
  logic [CNT_W-1:0]   item_limit;
  logic [7:0]         node_id;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_limit <= '0;
      item_limit <= '0;
      node_id    <= 8'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_BYTE_LIMIT: byte_limit <= cfg_data;
        CFG_ITEM_LIMIT: item_limit <= cfg_data[CNT_W-1:0];
        CFG_NODE_ID:    node_id    <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Entry storage.
  logic [ENTRIES-1:0] ent_valid;
  logic [KEY_BITS-1:0] ent_key [ENTRIES];
  logic [LEN_BITS-1:0] ent_len [ENTRIES];
  logic [31:0]         ent_word [ENTRIES];
  logic [IDX_W-1:0]    rank [ENTRIES];
  logic [BYTES_W-1:0]  stored_bytes;
  logic [CNT_W-1:0]    stored_count;

  // Latched request.
  logic [1:0]          r_kind;
  logic [KEY_BITS-1:0] r_key;
  logic [LEN_BITS-1:0] r_len;
  logic [31:0]         r_word;
  logic [7:0]          r_src;
  logic [31:0]         r_time;

  // Sequencer registers.
  state_t state, state_next;
  logic [IDX_W-1:0] slot;
  logic             found;
  logic [IDX_W-1:0] hit;
  logic             have_free;
  logic [IDX_W-1:0] free_slot;
  logic             have_tail;
  logic [IDX_W-1:0] tail;
  logic             tail_insert;  // tail search made room for an insert
  logic [1:0]       fin_status;
  logic [LEN_BITS-1:0] fin_len;
  logic [31:0]      fin_word;

  logic accept;
  assign accept = start && !busy;
  assign busy = (state != S_IDLE);

  logic slot_last;
  assign slot_last = (slot == IDX_W'(ENTRIES - 1));

  logic over;
  assign over = (byte_limit != '0 && stored_bytes > byte_limit) ||
                (item_limit != '0 && stored_count > item_limit);

  // Next-state logic.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (accept) state_next = S_SCAN;
      S_SCAN:  if (slot_last) state_next = S_ACT;
      S_ACT: begin
        if (r_kind == KIND_SET && r_key != '0 && r_len != '0 &&
            !(byte_limit != '0 && BYTES_W'(r_len) > byte_limit)) begin
          if (found) state_next = S_LIMIT;
          else if (stored_count >= CNT_W'(ENTRIES)) state_next = S_TAIL;
          else state_next = S_LIMIT;
        end else state_next = S_DONE;
      end
      S_TAIL:  if (slot_last) state_next = S_DROP;
      S_DROP:  state_next = tail_insert ? S_SCAN : S_LIMIT;
      S_LIMIT: state_next = over ? S_TAIL : S_DONE;
      S_DONE:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  // Datapath and results.
  always_ff @(posedge clk) begin
    if (rst) begin
      ent_valid    <= '0;
      stored_bytes <= '0;
      stored_count <= '0;
      out_valid    <= 1'b0;
      tail_insert  <= 1'b0;
      for (int i = 0; i < ENTRIES; i++) rank[i] <= '0;
    end else begin
      out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            r_kind <= kind; r_key <= key; r_len <= set_len;
            r_word <= value_word; r_src <= source_id; r_time <= req_time;
            slot <= '0; found <= 1'b0; have_free <= 1'b0;
            tail_insert <= 1'b0;
          end
        end
        S_SCAN: begin
          // One key compare per cycle; also remember the first free slot.
          if (ent_valid[slot] && ent_key[slot] == r_key && !found) begin
            found <= 1'b1; hit <= slot;
          end
          if (!ent_valid[slot] && !have_free) begin
            have_free <= 1'b1; free_slot <= slot;
          end
          slot <= slot + 1'b1;
          if (slot_last && tail_insert) begin
            // Second pass after making room: the insert follows in the action state.
            tail_insert <= 1'b0;
          end
        end
        S_ACT: begin
          fin_status <= ST_OK; fin_len <= '0; fin_word <= '0;
          slot <= '0; have_tail <= 1'b0;
          unique case (r_kind)
            KIND_SET: begin
              if (r_key == '0 || r_len == '0) fin_status <= ST_INVALID;
              else if (byte_limit != '0 && BYTES_W'(r_len) > byte_limit)
                fin_status <= ST_NO_SPACE;
              else if (found) begin
                stored_bytes <= stored_bytes - BYTES_W'(ent_len[hit]) +
                                BYTES_W'(r_len);
                ent_len[hit] <= r_len; ent_word[hit] <= r_word;
                for (int i = 0; i < ENTRIES; i++)
                  if (ent_valid[i] && rank[i] < rank[hit]) rank[i] <= rank[i] + 1'b1;
                rank[hit] <= '0;
                out_valid <= 1'b1; event_kind <= EV_UPDATED; status <= ST_OK;
                event_key <= r_key; event_len <= r_len; read_word <= '0;
                event_source <= r_src; event_time <= r_time; last <= 1'b0;
                entry_count <= stored_count;
                bytes_used <= stored_bytes - BYTES_W'(ent_len[hit]) +
                              BYTES_W'(r_len);
              end else if (stored_count >= CNT_W'(ENTRIES)) begin
                tail_insert <= 1'b1;
              end else begin
                for (int i = 0; i < ENTRIES; i++)
                  if (ent_valid[i]) rank[i] <= rank[i] + 1'b1;
                ent_valid[free_slot] <= 1'b1; ent_key[free_slot] <= r_key;
                ent_len[free_slot] <= r_len; ent_word[free_slot] <= r_word;
                rank[free_slot] <= '0;
                stored_bytes <= stored_bytes + BYTES_W'(r_len);
                stored_count <= stored_count + 1'b1;
                out_valid <= 1'b1; event_kind <= EV_ADDED; status <= ST_OK;
                event_key <= r_key; event_len <= r_len; read_word <= '0;
                event_source <= r_src; event_time <= r_time; last <= 1'b0;
                entry_count <= stored_count + 1'b1;
                bytes_used <= stored_bytes + BYTES_W'(r_len);
              end
            end
            KIND_GET: begin
              if (r_key == '0 || !found) fin_status <= ST_NOT_FND;
              else begin
                fin_len <= ent_len[hit]; fin_word <= ent_word[hit];
                for (int i = 0; i < ENTRIES; i++)
                  if (ent_valid[i] && rank[i] < rank[hit]) rank[i] <= rank[i] + 1'b1;
                rank[hit] <= '0;
              end
            end
            KIND_DEL: begin
              if (r_key == '0 || !found) fin_status <= ST_NOT_FND;
              else begin
                for (int i = 0; i < ENTRIES; i++)
                  if (ent_valid[i] && rank[i] > rank[hit]) rank[i] <= rank[i] - 1'b1;
                ent_valid[hit] <= 1'b0; rank[hit] <= '0;
                stored_bytes <= stored_bytes - BYTES_W'(ent_len[hit]);
                stored_count <= stored_count - 1'b1;
                out_valid <= 1'b1; event_kind <= EV_EVICTED; status <= ST_OK;
                event_key <= ent_key[hit]; event_len <= '0; read_word <= '0;
                event_source <= r_src; event_time <= r_time; last <= 1'b0;
                entry_count <= stored_count - 1'b1;
                bytes_used <= stored_bytes - BYTES_W'(ent_len[hit]);
              end
            end
            default: fin_status <= ST_INVALID;
          endcase
        end
        S_TAIL: begin
          // Walk the ranks for the least recent valid entry.
          if (ent_valid[slot] && (!have_tail || rank[slot] > rank[tail])) begin
            have_tail <= 1'b1; tail <= slot;
          end
          slot <= slot + 1'b1;
        end
        S_DROP: begin
          slot <= '0; found <= 1'b0; have_free <= 1'b0;
          if (have_tail) begin
            for (int i = 0; i < ENTRIES; i++)
              if (ent_valid[i] && rank[i] > rank[tail]) rank[i] <= rank[i] - 1'b1;
            ent_valid[tail] <= 1'b0; rank[tail] <= '0;
            stored_bytes <= stored_bytes - BYTES_W'(ent_len[tail]);
            stored_count <= stored_count - 1'b1;
            out_valid <= 1'b1; event_kind <= EV_EVICTED; status <= ST_OK;
            event_key <= ent_key[tail]; event_len <= '0; read_word <= '0;
            event_source <= node_id; event_time <= '0; last <= 1'b0;
            entry_count <= stored_count - 1'b1;
            bytes_used <= stored_bytes - BYTES_W'(ent_len[tail]);
          end
        end
        S_LIMIT: begin
          slot <= '0; have_tail <= 1'b0;
        end
        S_DONE: begin
          out_valid <= 1'b1; event_kind <= EV_STATUS; status <= fin_status;
          event_key <= r_key; event_len <= fin_len; read_word <= fin_word;
          event_source <= r_src; event_time <= r_time; last <= 1'b1;
          entry_count <= stored_count; bytes_used <= stored_bytes;
        end
        default: ;
      endcase
    end
  end

  `ASSERT_IMPL(a_count_range, clk, rst, 1'b1, stored_count <= CNT_W'(ENTRIES))
  `ASSERT_NEXT(a_done_last, clk, rst, state == S_DONE, out_valid && last)
  `ASSERT_IMPL(a_busy_idle, clk, rst, state == S_IDLE, !busy)
  `ASSERT_NEXT(a_accept_busy, clk, rst, accept, busy)

endmodule

// ===== bench/lru_key_value_store_tb.sv =====
`timescale 1ns / 1ps
module lru_key_value_store_tb
  import lkv_pkg::*;
();

  // One request as the sender presents it.
  typedef struct {
    logic [1:0]          kind;
    logic [KEY_BITS-1:0] key;
    logic [LEN_BITS-1:0] len;
    logic [31:0]         word;
    logic [7:0]          src;
    logic [31:0]         tm;
  } request_t;

  // One event or status beat as the store emits it.
  typedef struct {
    event_t              ev;
    status_t             st;
    logic [KEY_BITS-1:0] key;
    logic [LEN_BITS-1:0] len;
    logic [31:0]         word;
    logic [7:0]          src;
    logic [31:0]         tm;
    logic [CNT_W-1:0]    cnt;
    logic [BYTES_W-1:0]  bytes;
    logic                last;
  } store_event_t;

  localparam int WATCHDOG_LIMIT = 20000;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                start = 1'b0;
  logic                busy;
  logic [1:0]          kind = '0;
  logic [KEY_BITS-1:0] key = '0;
  logic [LEN_BITS-1:0] set_len = '0;
  logic [31:0]         value_word = '0;
  logic [7:0]          source_id = '0;
  logic [31:0]         req_time = '0;
  logic                cfg_we = 1'b0;
  logic [1:0]          cfg_index = '0;
  logic [25:0]         cfg_data = '0;
  logic                out_valid;
  logic [1:0]          event_kind;
  logic [1:0]          status;
  logic [KEY_BITS-1:0] event_key;
  logic [LEN_BITS-1:0] event_len;
  logic [31:0]         read_word;
  logic [7:0]          event_source;
  logic [31:0]         event_time;
  logic [CNT_W-1:0]    entry_count;
  logic [BYTES_W-1:0]  bytes_used;
  logic                last;

  lru_key_value_store uut (.*);

  always #10 clk = ~clk;

  // Shadow copy of the store and its registers.
  logic                lru_valid [ENTRIES];
  logic [KEY_BITS-1:0] lru_key [ENTRIES];
  logic [LEN_BITS-1:0] lru_len [ENTRIES];
  logic [31:0]         lru_word [ENTRIES];
  int                  lru_rank [ENTRIES];
  int unsigned         lru_bytes;
  int unsigned         lru_count;
  int unsigned         lim_bytes;
  int unsigned         lim_items;
  logic [7:0]          own_node;

  request_t     pending_reqs[$];
  store_event_t expected_events[$];
  int           mismatches = 0;
  int           idle_cycles = 0;
  int           gap_left = 0;
  bit           calm = 1'b0;
  request_t     cur;

  task automatic report(input string msg);
    $display("%0t mismatch: %s", $time, msg);
    mismatches++;
  endtask

  function automatic void push_event(event_t ev, status_t st, logic [KEY_BITS-1:0] k,
                                     logic [LEN_BITS-1:0] l, logic [31:0] w,
                                     logic [7:0] s, logic [31:0] t, logic lst);
    store_event_t e;
    e.ev = ev; e.st = st; e.key = k; e.len = l; e.word = w; e.src = s; e.tm = t;
    e.cnt = lru_count[CNT_W-1:0];
    e.bytes = lru_bytes[BYTES_W-1:0];
    e.last = lst;
    expected_events.push_back(e);
  endfunction

  function automatic int lookup(logic [KEY_BITS-1:0] k);
    for (int i = 0; i < ENTRIES; i++)
      if (lru_valid[i] && lru_key[i] == k) return i;
    return -1;
  endfunction

  function automatic int oldest_slot();
    int t;
    t = -1;
    for (int i = 0; i < ENTRIES; i++)
      if (lru_valid[i] && (t < 0 || lru_rank[i] > lru_rank[t])) t = i;
    return t;
  endfunction

  function automatic void touch(int s);
    for (int i = 0; i < ENTRIES; i++)
      if (lru_valid[i] && lru_rank[i] < lru_rank[s]) lru_rank[i]++;
    lru_rank[s] = 0;
  endfunction

  function automatic void evict(int s, logic [7:0] src, logic [31:0] t);
    lru_valid[s] = 1'b0;
    for (int i = 0; i < ENTRIES; i++)
      if (lru_valid[i] && lru_rank[i] > lru_rank[s]) lru_rank[i]--;
    lru_rank[s] = 0;
    lru_bytes -= lru_len[s];
    lru_count--;
    push_event(EV_EVICTED, ST_OK, lru_key[s], '0, '0, src, t, 1'b0);
  endfunction

  // Apply one accepted request to the shadow store and queue its events.
  function automatic void predict_request(request_t r);
    status_t st;
    int s;
    logic [LEN_BITS-1:0] rlen;
    logic [31:0] rword;
    st = ST_OK; rlen = '0; rword = '0;
    if (r.kind == KIND_SET) begin
      if (r.key == 0 || r.len == 0) begin
        st = ST_INVALID;
      end else if (lim_bytes != 0 && r.len > lim_bytes) begin
        st = ST_NO_SPACE;
      end else begin
        s = lookup(r.key);
        if (s >= 0) begin
          lru_bytes = lru_bytes - lru_len[s] + r.len;
          lru_len[s] = r.len;
          lru_word[s] = r.word;
          touch(s);
          push_event(EV_UPDATED, ST_OK, r.key, r.len, '0, r.src, r.tm, 1'b0);
        end else begin
          if (lru_count >= ENTRIES) evict(oldest_slot(), own_node, '0);
          s = 0;
          while (lru_valid[s]) s++;
          for (int i = 0; i < ENTRIES; i++)
            if (lru_valid[i]) lru_rank[i]++;
          lru_valid[s] = 1'b1;
          lru_key[s] = r.key;
          lru_len[s] = r.len;
          lru_word[s] = r.word;
          lru_rank[s] = 0;
          lru_bytes += r.len;
          lru_count++;
          push_event(EV_ADDED, ST_OK, r.key, r.len, '0, r.src, r.tm, 1'b0);
        end
        // Trim from the least recent end while a limit is exceeded.
        while ((lim_bytes != 0 && lru_bytes > lim_bytes) ||
               (lim_items != 0 && lru_count > lim_items))
          evict(oldest_slot(), own_node, '0);
      end
    end else if (r.kind == KIND_GET || r.kind == KIND_DEL) begin
      s = (r.key == 0) ? -1 : lookup(r.key);
      if (s < 0) begin
        st = ST_NOT_FND;
      end else if (r.kind == KIND_GET) begin
        rlen = lru_len[s];
        rword = lru_word[s];
        touch(s);
      end else begin
        evict(s, r.src, r.tm);
      end
    end else begin
      st = ST_INVALID;
    end
    push_event(EV_STATUS, st, r.key, rlen, rword, r.src, r.tm, 1'b1);
  endfunction

  // Sender: holds a request until it is taken, with random gaps between beats.
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) predict_request(cur);
      if (!(start && busy)) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          start <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          cur = pending_reqs.pop_front();
          kind <= cur.kind;
          key <= cur.key;
          set_len <= cur.len;
          value_word <= cur.word;
          source_id <= cur.src;
          req_time <= cur.tm;
          start <= 1'b1;
          if (!calm && $urandom_range(0, 3) == 0) gap_left <= $urandom_range(1, 9);
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Receiver: every strobed beat is checked against the oldest expectation.
  always @(posedge clk) begin
    store_event_t e;
    if (!rst && out_valid) begin
      if (expected_events.size() == 0) begin
        report($sformatf("unexpected beat kind %0d key %h", event_kind, event_key));
      end else begin
        e = expected_events.pop_front();
        if (event_kind !== e.ev) report($sformatf("event_kind %0d exp %0d", event_kind, e.ev));
        if (status !== e.st) report($sformatf("status %0d exp %0d", status, e.st));
        if (event_key !== e.key) report($sformatf("event_key %h exp %h", event_key, e.key));
        if (event_len !== e.len) report($sformatf("event_len %0d exp %0d", event_len, e.len));
        if (read_word !== e.word) report($sformatf("read_word %h exp %h", read_word, e.word));
        if (event_source !== e.src)
          report($sformatf("event_source %0d exp %0d", event_source, e.src));
        if (event_time !== e.tm) report($sformatf("event_time %h exp %h", event_time, e.tm));
        if (entry_count !== e.cnt)
          report($sformatf("entry_count %0d exp %0d", entry_count, e.cnt));
        if (bytes_used !== e.bytes)
          report($sformatf("bytes_used %0d exp %0d", bytes_used, e.bytes));
        if (last !== e.last) report($sformatf("last %b exp %b", last, e.last));
      end
    end
  end

  // Watchdog on cycles in which no beat moves on either side.
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic add_request(logic [1:0] k, logic [KEY_BITS-1:0] ky, logic [LEN_BITS-1:0] l);
    request_t r;
    r.kind = k; r.key = ky; r.len = l;
    r.word = $urandom; r.src = 8'($urandom); r.tm = $urandom;
    pending_reqs.push_back(r);
  endtask

  // Random traffic: mostly keys from a small pool so that hits, updates and
  // evictions are common; some wide keys, zero keys and bad lengths.
  task automatic add_random(int n, int max_len);
    logic [1:0] k;
    logic [KEY_BITS-1:0] ky;
    logic [LEN_BITS-1:0] l;
    int p;
    for (int i = 0; i < n; i++) begin
      p = $urandom_range(0, 99);
      k = (p < 50) ? KIND_SET : (p < 78) ? KIND_GET : (p < 95) ? KIND_DEL : KIND_RSVD;
      p = $urandom_range(0, 99);
      if (p < 80) ky = 64'($urandom_range(1, 40));
      else if (p < 85) ky = '0;
      else ky = {$urandom, $urandom};
      p = $urandom_range(0, 99);
      if (p < 85) l = 20'($urandom_range(1, max_len));
      else if (p < 97) l = 20'($urandom);
      else l = '0;
      add_request(k, ky, l);
    end
  endtask

  // Wait until the store has answered everything, then let it settle.
  task automatic drain();
    while (pending_reqs.size() > 0 || start || expected_events.size() > 0)
      @(negedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_limits(int unsigned bl, int unsigned il, logic [7:0] nid);
    @(posedge clk);
    cfg_we <= 1'b1; cfg_index <= CFG_BYTE_LIMIT; cfg_data <= 26'(bl);
    @(posedge clk);
    cfg_index <= CFG_ITEM_LIMIT; cfg_data <= 26'(il);
    @(posedge clk);
    cfg_index <= CFG_NODE_ID; cfg_data <= {18'd0, nid};
    @(posedge clk);
    cfg_we <= 1'b0;
    lim_bytes = bl & 26'h3FFFFFF;
    lim_items = il & 6'h3F;
    own_node = nid;
  endtask

  initial begin
    for (int i = 0; i < ENTRIES; i++) begin
      lru_valid[i] = 1'b0; lru_key[i] = '0; lru_len[i] = '0;
      lru_word[i] = '0; lru_rank[i] = 0;
    end
    lru_bytes = 0; lru_count = 0; lim_bytes = 0; lim_items = 0; own_node = 8'd1;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed requests under the reset limits.
    add_request(KIND_SET, '1, '1);
    add_request(KIND_GET, '1, '0);
    add_request(KIND_SET, '1, 20'd5);
    add_request(KIND_SET, 64'd1, 20'd1);
    add_request(KIND_GET, 64'd1, '0);
    add_request(KIND_GET, 64'd2, '0);
    add_request(KIND_GET, '0, '0);
    add_request(KIND_SET, '0, 20'd4);
    add_request(KIND_SET, 64'd3, '0);
    add_request(KIND_RSVD, 64'd1, 20'd1);
    add_request(KIND_DEL, '0, '0);
    add_request(KIND_DEL, 64'd9, '0);
    add_request(KIND_DEL, '1, '0);
    // Overfill the store so that the oldest entry goes on insert.
    for (int i = 0; i < 34; i++) add_request(KIND_SET, 64'd100 + i, 20'd3);
    add_random(70, 2000);
    drain();

    // Tight item limit with a high node id.
    write_limits(0, 4, 8'd200);
    add_random(90, 2000);
    drain();

    // Small byte limit: long sets are refused, short ones evict.
    write_limits(3000, 0, 8'd7);
    add_random(90, 1000);
    drain();

    // Smallest limits.
    write_limits(1, 1, 8'd1);
    add_random(40, 3);
    drain();

    // Large limits, item limit at full size; last stretch with no gaps.
    write_limits(33554432, 32, 8'd255);
    add_random(73, 2000);
    while (pending_reqs.size() > 30) @(negedge clk);
    calm = 1'b1;
    drain();

    if (mismatches == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end
endmodule
